### hw/rtl/cai_pkg.sv
`default_nettype none

package cai_pkg;

  // Width of the serial unit's cycle counter (it counts up to 64 steps).
  localparam int unsigned MD_CW = 7;
  localparam int unsigned MUL_STEPS = 32;
  localparam int unsigned DIV_STEPS = 64;

  // CORDIC iteration index width; the arctangent table has 24 entries.
  localparam int unsigned CORDIC_IW = 5;

  localparam logic [31:0] ANG_PER_RAD = 32'd683565276;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] MS_PER_S = 32'd1000;
  localparam logic [63:0] MS_HALF = 64'd500;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_op_e;

  typedef struct packed {
    logic        start;
    md_op_e      op;
    logic [63:0] a;
    logic [31:0] b;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } md_rsp_t;

  typedef enum logic [1:0] {
    CFG_SPEED       = 2'd0,
    CFG_ARC_LENGTH  = 2'd1,
    CFG_TURN_RADIUS = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST_MUL,
    ST_DIST_DIV,
    ST_STEP_MUL,
    ST_STEP_DIV,
    ST_TGT_MUL,
    ST_TGT_DIV,
    ST_SINCOS,
    ST_MUL_X,
    ST_MUL_Y,
    ST_RESULT
  } state_e;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [31:0] atan_lookup(input logic [CORDIC_IW-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Clamp a wide signed value to the int32 range.
  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Signed angle from a quotient magnitude, saturated at half a turn.
  function automatic logic [31:0] angle_sat(input logic [63:0] q, input logic neg);
    logic [31:0] r;
    if (!neg) begin
      r = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      r = (q > 64'h8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    end
    return r;
  endfunction

  // Q16.16 times Q2.30 product magnitude, rounded half away from zero.
  function automatic logic signed [35:0] mul_term(input logic [63:0] p, input logic neg);
    logic [63:0] sum;
    logic [35:0] q;
    sum = p + 64'd536870912;
    q = {2'b00, sum[63:30]};
    return neg ? $signed(~q + 36'd1) : $signed(q);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/cai_muldiv.sv
`default_nettype none

// Bit-serial unsigned multiplier (32 steps) and restoring divider (64 steps).
module cai_muldiv (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cai_pkg::md_req_t req_i,
  output cai_pkg::md_rsp_t      rsp_o
);
  import cai_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  md_op_e           op_q, op_d;
  logic [MD_CW-1:0] cnt_q, cnt_d;
  logic [63:0]      acc_q, acc_d;
  logic [63:0]      mc_q, mc_d;
  logic [31:0]      mr_q, mr_d;
  logic [31:0]      rem_q, rem_d;
  logic [32:0]      trial;
  logic [32:0]      diff;

  // One multiplier bit or one quotient bit per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    mc_d   = mc_q;
    mr_d   = mr_q;
    rem_d  = rem_q;
    trial  = {rem_q, mc_q[63]};
    diff   = trial - {1'b0, mr_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      mc_d   = req_i.a;
      mr_d   = req_i.b;
      acc_d  = '0;
      rem_d  = '0;
      cnt_d  = (req_i.op == MD_MUL) ? MD_CW'(MUL_STEPS - 1) : MD_CW'(DIV_STEPS - 1);
    end else if (busy_q) begin
      if (op_q == MD_MUL) begin
        if (mr_q[0]) begin
          acc_d = acc_q + mc_q;
        end
        mc_d = {mc_q[62:0], 1'b0};
        mr_d = {1'b0, mr_q[31:1]};
      end else begin
        // The dividend shifts out of mc at the top, quotient bits enter at the bottom.
        if (!diff[32]) begin
          rem_d = diff[31:0];
          mc_d  = {mc_q[62:0], 1'b1};
        end else begin
          rem_d = trial[31:0];
          mc_d  = {mc_q[62:0], 1'b0};
        end
      end
      cnt_d = cnt_q - MD_CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= MD_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mr_q  <= mr_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = (op_q == MD_MUL) ? acc_q : mc_q;

endmodule

`default_nettype wire

### hw/rtl/cai_cordic.sv
`default_nettype none

// Iterative CORDIC in rotation mode: one micro-rotation per cycle.
module cai_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [31:0]        angle_i,
  output logic                    done_o,
  output logic signed [33:0]      sin_o,
  output logic signed [33:0]      cos_o
);
  import cai_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic                  flip_q, flip_d;
  logic [CORDIC_IW-1:0]  idx_q, idx_d;
  logic signed [33:0]    x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [33:0]    dx, dy, at;
  logic                  fold;
  logic [31:0]           ang;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    flip_d = flip_q;
    idx_d  = idx_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    dx     = y_q >>> idx_q;
    dy     = x_q >>> idx_q;
    at     = $signed({2'b00, atan_lookup(idx_q)});
    // Fold the left half-plane onto the right one and negate at the end.
    fold   = |((angle_i + QUARTER_TURN) & HALF_TURN);
    ang    = fold ? (angle_i ^ HALF_TURN) : angle_i;
    if (start_i) begin
      busy_d = 1'b1;
      flip_d = fold;
      idx_d  = '0;
      x_d    = CORDIC_GAIN;
      y_d    = '0;
      z_d    = $signed({{2{ang[31]}}, ang});
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end
      idx_d = idx_q + CORDIC_IW'(1);
      if (idx_q == CORDIC_IW'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flip_q <= flip_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  assign done_o = done_q;
  assign sin_o  = flip_q ? -y_q : y_q;
  assign cos_o  = flip_q ? -x_q : x_q;

endmodule

`default_nettype wire

### hw/rtl/circular_arc_interpolator.sv
`default_nettype none
// A start item with a nonzero radius runs five serial multiplies and three serial
// divides, with CORDIC before the last two multiplies. A tick that moves the pose
// runs CORDIC and two serial multiplies; any other item goes straight to the result.
// One item at a time; the next is accepted in the cycle after a result is
// registered, even while that beat waits. Reset (rst_ni, asynchronous, active low)
// clears the pose, goes idle and sets speed 1.0, arc length 1.0, radius 1.0.
module circular_arc_interpolator #(
  parameter int unsigned TICK_MS      = 10,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               action_i,
  input  wire logic signed [31:0] start_x_i,
  input  wire logic signed [31:0] start_y_i,
  input  wire logic [15:0]        start_heading_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic [15:0]             heading_o,
  output logic                    moved_o,
  output logic                    finished_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  import cai_pkg::*;

  state_e             state_q, state_d;
  logic               issue_q;
  logic [30:0]        speed_q, arc_q;
  logic signed [31:0] radius_q;
  logic signed [31:0] cur_x_q, cur_y_q, centre_x_q, centre_y_q;
  logic [31:0]        heading_q;
  logic signed [31:0] swept_q, step_q, target_q;
  logic [31:0]        dist_q;
  logic               active_q, moved_q, is_start_q;
  logic               out_valid_q;
  logic signed [31:0] out_x_q, out_y_q;
  logic [15:0]        out_h_q;
  logic               out_moved_q, out_fin_q;

  md_req_t            md_req;
  md_rsp_t            md_rsp;
  logic               cs_start, cs_done;
  logic signed [33:0] cs_sin, cs_cos;

  logic               in_fire, out_free, r_neg;
  logic [31:0]        r_mag, s_mag, c_mag;
  logic signed [32:0] next_swept;
  logic signed [32:0] target_ext;
  logic               tick_done;
  logic signed [35:0] term;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign r_neg       = radius_q[31];
  assign r_mag       = r_neg ? (~radius_q + 32'd1) : radius_q;
  assign s_mag       = cs_sin[33] ? 32'(-cs_sin) : cs_sin[31:0];
  assign c_mag       = cs_cos[33] ? 32'(-cs_cos) : cs_cos[31:0];
  assign next_swept  = {swept_q[31], swept_q} + {step_q[31], step_q};
  assign target_ext  = $signed({target_q[31], target_q});
  assign tick_done   = (radius_q > 32'sd0) ? (next_swept > target_ext)
                                           : (next_swept < target_ext);
  assign term        = mul_term(md_rsp.result,
                                (state_q == ST_MUL_X) ? (r_neg ^ cs_sin[33])
                                                      : (r_neg ^ cs_cos[33]));

  // Operand selection for the shared serial multiply/divide unit.
  always_comb begin
    md_req.start = issue_q;
    md_req.op    = MD_MUL;
    md_req.a     = '0;
    md_req.b     = '0;
    unique case (state_q)
      ST_DIST_MUL: begin
        md_req.a = {33'd0, speed_q};
        md_req.b = 32'(TICK_MS);
      end
      ST_DIST_DIV: begin
        md_req.op = MD_DIV;
        md_req.a  = md_rsp.result + MS_HALF;
        md_req.b  = MS_PER_S;
      end
      ST_STEP_MUL: begin
        md_req.a = {32'd0, dist_q};
        md_req.b = ANG_PER_RAD;
      end
      ST_TGT_MUL: begin
        md_req.a = {33'd0, arc_q};
        md_req.b = ANG_PER_RAD;
      end
      ST_STEP_DIV, ST_TGT_DIV: begin
        md_req.op = MD_DIV;
        md_req.a  = md_rsp.result;
        md_req.b  = r_mag;
      end
      ST_MUL_X: begin
        md_req.a = {32'd0, r_mag};
        md_req.b = s_mag;
      end
      ST_MUL_Y: begin
        md_req.a = {32'd0, r_mag};
        md_req.b = c_mag;
      end
      default: begin
        md_req.start = 1'b0;
      end
    endcase
  end

  assign cs_start = issue_q && (state_q == ST_SINCOS);

  cai_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  cai_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cs_start),
    .angle_i (heading_q),
    .done_o  (cs_done),
    .sin_o   (cs_sin),
    .cos_o   (cs_cos)
  );

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!action_i) begin
            state_d = (radius_q == 32'sd0) ? ST_RESULT : ST_DIST_MUL;
          end else begin
            state_d = (active_q && !tick_done) ? ST_SINCOS : ST_RESULT;
          end
        end
      end
      ST_DIST_MUL: if (md_rsp.done) state_d = ST_DIST_DIV;
      ST_DIST_DIV: if (md_rsp.done) state_d = ST_STEP_MUL;
      ST_STEP_MUL: if (md_rsp.done) state_d = ST_STEP_DIV;
      ST_STEP_DIV: if (md_rsp.done) state_d = ST_TGT_MUL;
      ST_TGT_MUL:  if (md_rsp.done) state_d = ST_TGT_DIV;
      ST_TGT_DIV:  if (md_rsp.done) state_d = ST_SINCOS;
      ST_SINCOS:   if (cs_done)     state_d = ST_MUL_X;
      ST_MUL_X:    if (md_rsp.done) state_d = ST_MUL_Y;
      ST_MUL_Y:    if (md_rsp.done) state_d = ST_RESULT;
      ST_RESULT:   if (out_free)    state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Control registers; a unit is started in the first cycle of its state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_q     <= 1'b0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      speed_q     <= 31'd65536;
      arc_q       <= 31'd65536;
      radius_q    <= 32'sd65536;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      centre_x_q  <= '0;
      centre_y_q  <= '0;
      heading_q   <= '0;
      swept_q     <= '0;
      step_q      <= '0;
      target_q    <= '0;
    end else begin
      state_q <= state_d;
      issue_q <= (state_d != state_q);

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_SPEED:       speed_q  <= cfg_data_i[30:0];
          CFG_ARC_LENGTH:  arc_q    <= cfg_data_i[30:0];
          CFG_TURN_RADIUS: radius_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == ST_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (!action_i) begin
              cur_x_q   <= start_x_i;
              cur_y_q   <= start_y_i;
              heading_q <= {start_heading_i, 16'd0};
              swept_q   <= '0;
              if (radius_q == 32'sd0) begin
                centre_x_q <= start_x_i;
                centre_y_q <= start_y_i;
                step_q     <= '0;
                target_q   <= '0;
                active_q   <= 1'b0;
              end else begin
                active_q <= 1'b1;
              end
            end else if (active_q) begin
              if (tick_done) begin
                active_q <= 1'b0;
              end else begin
                swept_q   <= next_swept[31:0];
                heading_q <= heading_q + step_q;
              end
            end
          end
        end
        ST_STEP_DIV: if (md_rsp.done) step_q <= angle_sat(md_rsp.result, r_neg);
        ST_TGT_DIV:  if (md_rsp.done) target_q <= angle_sat(md_rsp.result, r_neg);
        ST_MUL_X: begin
          if (md_rsp.done) begin
            if (is_start_q) begin
              centre_x_q <= sat32(36'(cur_x_q) - term);
            end else begin
              cur_x_q <= sat32(36'(centre_x_q) + term);
            end
          end
        end
        ST_MUL_Y: begin
          if (md_rsp.done) begin
            if (is_start_q) begin
              centre_y_q <= sat32(36'(cur_y_q) + term);
            end else begin
              cur_y_q <= sat32(36'(centre_y_q) - term);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Per-item flags, distance per tick and the output beat registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      is_start_q <= !action_i;
      moved_q    <= action_i && active_q && !tick_done;
    end
    if (state_q == ST_DIST_DIV && md_rsp.done) begin
      dist_q <= md_rsp.result[31:0];
    end
    if (state_q == ST_RESULT && out_free) begin
      out_x_q     <= cur_x_q;
      out_y_q     <= cur_y_q;
      out_h_q     <= heading_q[31:16];
      out_moved_q <= moved_q;
      out_fin_q   <= !active_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;
  assign heading_o   = out_h_q;
  assign moved_o     = out_moved_q;
  assign finished_o  = out_fin_q;

endmodule

`default_nettype wire
